// File: rtl/rwss_pkg.sv
`timescale 1ns / 1ps

package rwss_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int SCREEN_ROWS = 1024;

  localparam int DIST_W   = 32;
  localparam int POS_W    = 32;
  localparam int DIR_W    = 20;
  localparam int BS_W     = 13;
  localparam int PD_W     = 16;
  localparam int TW_W     = 13;
  localparam int CFG_W    = 16;
  localparam int HEIGHT_W = 16;
  localparam int ROW_W    = 13;
  localparam int COL_W    = 12;
  localparam int BP_W     = BS_W + PD_W;

  localparam logic [BS_W-1:0] BLOCK_SIZE_RST     = BS_W'(64);
  localparam logic [PD_W-1:0] PLANE_DISTANCE_RST = PD_W'(512);
  localparam logic [TW_W-1:0] TEX_WIDTH_RST      = TW_W'(64);

  typedef enum logic [1:0] {
    CFG_BLOCK_SIZE     = 2'd0,
    CFG_PLANE_DISTANCE = 2'd1,
    CFG_TEX_WIDTH      = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FACE_EAST  = 2'd0,
    FACE_WEST  = 2'd1,
    FACE_SOUTH = 2'd2,
    FACE_NORTH = 2'd3
  } face_t;

  // Payload carried through the divider stages alongside each item.
  typedef struct packed {
    face_t               face;
    logic                sat;
    logic [COL_W-1:0]    col;
    logic [DIST_W-1:0]   divisor;
    logic [DIST_W-1:0]   rem;
    logic [HEIGHT_W-1:0] quo;
  } div_t;

endpackage

// File: rtl/rwss_div_step.sv
`timescale 1ns / 1ps

module rwss_div_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          d_valid,
  input  rwss_pkg::div_t d,
  output logic          q_valid,
  output rwss_pkg::div_t q
);
  import rwss_pkg::*;

  logic [DIST_W:0]   rem_sh;
  logic [DIST_W:0]   diff;
  logic              ge;
  div_t              q_next;

  // One restoring step: in an unsaturated item the remainder is below the
  // divisor; the shifted value fits one extra bit, the result fits DIST_W.
  always_comb begin
    rem_sh = {d.rem, 1'b0};
    diff   = rem_sh - {1'b0, d.divisor};
    ge     = (rem_sh >= {1'b0, d.divisor});
    q_next = d;
    q_next.rem = ge ? diff[DIST_W-1:0] : rem_sh[DIST_W-1:0];
    q_next.quo = {d.quo[HEIGHT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

// File: rtl/raycast_wall_slice_setup.sv
`timescale 1ns / 1ps

// Wall slice setup for a column raycaster. Each input item describes one
// screen column's wall hit; each output item gives the face seen, the
// projected wall height, the clamped start and end rows and the texture column.
// Input and output channels use valid/stall: an item moves on a rising edge
// where valid is high and stall is low.
// The block is a fixed pipeline of 20 register stages: a multiply stage, a
// compare and add stage, a texture multiply stage, one stage per quotient bit
// of the 16-bit height division, and an output stage. One item is accepted
// every cycle in which the output item is not held by out_stall.
// When the output item is held by out_stall the whole pipeline freezes and
// in_stall is raised in the same cycle; nothing is dropped or repeated.
// The configuration registers are written through cfg_we, cfg_index and
// cfg_data, and must only be changed while the pipeline is empty.
// Reset is synchronous: it empties the pipeline and loads block_size 64,
// plane_distance 512 and tex_width 64.
module raycast_wall_slice_setup (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [rwss_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rwss_pkg::DIST_W-1:0]   distance,
  input  logic                          horizontal_hit,
  input  logic                          step_x_positive,
  input  logic                          step_y_positive,
  input  logic [rwss_pkg::POS_W-1:0]    player_x,
  input  logic [rwss_pkg::POS_W-1:0]    player_y,
  input  logic signed [rwss_pkg::DIR_W-1:0] ray_dx,
  input  logic signed [rwss_pkg::DIR_W-1:0] ray_dy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    face,
  output logic [rwss_pkg::HEIGHT_W-1:0] slice_height,
  output logic [rwss_pkg::ROW_W-1:0]    start_row,
  output logic [rwss_pkg::ROW_W-1:0]    end_row,
  output logic [rwss_pkg::COL_W-1:0]    texture_column
);
  import rwss_pkg::*;

  localparam int TP_W = DIST_W + DIR_W + 1;
  localparam int CP_W = 2 * FRAC_BITS + TW_W;

  logic [BS_W-1:0] block_size;
  logic [PD_W-1:0] plane_distance;
  logic [TW_W-1:0] tex_width;

  logic adv;

  // Stage A inputs.
  face_t                   face_sel;
  logic signed [DIR_W-1:0] dir_sel;
  logic [FRAC_BITS-1:0]    pos_sel;
  logic [BP_W-1:0]         bp;
  logic signed [TP_W-1:0]  tprod_full;

  logic                    a_valid;
  face_t                   a_face;
  logic [DIST_W-1:0]       a_dist;
  logic [BP_W-1:0]         a_bp;
  logic [2*FRAC_BITS-1:0]  a_tprod;
  logic [FRAC_BITS-1:0]    a_pos;

  logic                    b_valid;
  face_t                   b_face;
  logic [DIST_W-1:0]       b_dist;
  logic                    b_sat;
  logic [DIST_W-1:0]       b_rem;
  logic [2*FRAC_BITS-1:0]  b_frac;

  logic [CP_W-1:0]         col_full;
  div_t                    c_next;
  logic                    c_valid;
  div_t                    c_div;

  logic                    dv_valid [0:HEIGHT_W];
  div_t                    dv       [0:HEIGHT_W];

  logic [HEIGHT_W-1:0]     height;
  logic [HEIGHT_W-1:0]     half;
  logic [HEIGHT_W-1:0]     half_rows;
  logic [HEIGHT_W-1:0]     start_diff;
  logic [ROW_W-1:0]        start_next;
  logic [HEIGHT_W:0]       end_sum;
  logic [ROW_W-1:0]        end_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size     <= BLOCK_SIZE_RST;
      plane_distance <= PLANE_DISTANCE_RST;
      tex_width      <= TEX_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BLOCK_SIZE:     block_size     <= cfg_data[BS_W-1:0];
        CFG_PLANE_DISTANCE: plane_distance <= cfg_data[PD_W-1:0];
        CFG_TEX_WIDTH:      tex_width      <= cfg_data[TW_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage A: face decode, numerator product and hit offset product.
  always_comb begin
    if (horizontal_hit) begin
      face_sel = step_y_positive ? FACE_SOUTH : FACE_NORTH;
      dir_sel  = ray_dx;
      pos_sel  = player_x[FRAC_BITS-1:0];
    end else begin
      face_sel = step_x_positive ? FACE_EAST : FACE_WEST;
      dir_sel  = ray_dy;
      pos_sel  = player_y[FRAC_BITS-1:0];
    end
    bp         = BP_W'(block_size) * BP_W'(plane_distance);
    tprod_full = $signed({1'b0, distance}) * dir_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_face  <= face_sel;
      a_dist  <= distance;
      a_bp    <= bp;
      a_tprod <= tprod_full[2*FRAC_BITS-1:0];
      a_pos   <= pos_sel;
    end
  end

  // Stage B: the quotient overflows 16 bits exactly when the product is not
  // below the distance, which also covers a zero distance. Only the fraction
  // of the hit coordinate is needed, so the sum wraps in its integer part.
  always_ff @(posedge clk) begin
    if (adv) begin
      b_face <= a_face;
      b_dist <= a_dist;
      b_sat  <= (DIST_W'(a_bp) >= a_dist);
      b_rem  <= DIST_W'(a_bp);
      b_frac <= {a_pos, {FRAC_BITS{1'b0}}} + a_tprod;
    end
  end

  // Stage C: texture column from the fraction, then into the divider.
  always_comb begin
    col_full       = CP_W'(b_frac) * CP_W'(tex_width);
    c_next.face    = b_face;
    c_next.sat     = b_sat;
    c_next.col     = col_full[2*FRAC_BITS +: COL_W];
    c_next.divisor = b_dist;
    c_next.rem     = b_rem;
    c_next.quo     = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_div <= c_next;
    end
  end

  assign dv_valid[0] = c_valid;
  assign dv[0]       = c_div;

  for (genvar i = 0; i < HEIGHT_W; i++) begin : g_div
    rwss_div_step u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .d_valid (dv_valid[i]),
      .d       (dv[i]),
      .q_valid (dv_valid[i+1]),
      .q       (dv[i+1])
    );
  end

  // Output stage: saturation, vertical centring and clamping.
  always_comb begin
    height     = dv[HEIGHT_W].sat ? '1 : dv[HEIGHT_W].quo;
    half       = height >> 1;
    half_rows  = HEIGHT_W'(SCREEN_ROWS / 2);
    start_diff = half_rows - half;
    start_next = (half >= half_rows) ? '0 : start_diff[ROW_W-1:0];
    end_sum    = (HEIGHT_W+1)'(start_next) + (HEIGHT_W+1)'(height);
    end_next   = (end_sum > (HEIGHT_W+1)'(SCREEN_ROWS)) ? ROW_W'(SCREEN_ROWS)
                                                        : end_sum[ROW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid[HEIGHT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      face           <= dv[HEIGHT_W].face;
      slice_height   <= height;
      start_row      <= start_next;
      end_row        <= end_next;
      texture_column <= dv[HEIGHT_W].col;
    end
  end

endmodule

// File: rtl/rwss_checker.sv
`timescale 1ns / 1ps

module rwss_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_stall,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [1:0]                    face,
  input  logic [rwss_pkg::HEIGHT_W-1:0] slice_height,
  input  logic [rwss_pkg::ROW_W-1:0]    start_row,
  input  logic [rwss_pkg::ROW_W-1:0]    end_row,
  input  logic [rwss_pkg::COL_W-1:0]    texture_column
);
  import rwss_pkg::*;

  // A held output item stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(face) && $stable(slice_height)
      && $stable(start_row) && $stable(end_row) && $stable(texture_column))
    else $error("output item changed while stalled");

  // The input is only held back by a stalled output item.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled while output free");

  // The slice lies on the screen and starts at or above the centre row.
  a_rows_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (end_row <= ROW_W'(SCREEN_ROWS))
      && (start_row <= ROW_W'(SCREEN_ROWS / 2)) && (start_row <= end_row))
    else $error("slice rows out of range");

  // An unclamped slice spans exactly the wall height.
  a_rows_span: assert property (@(posedge clk) disable iff (rst)
    out_valid && (start_row != '0) && (end_row != ROW_W'(SCREEN_ROWS))
      |-> (HEIGHT_W'(end_row - start_row) == slice_height))
    else $error("slice span differs from wall height");

endmodule

bind raycast_wall_slice_setup rwss_checker u_rwss_checker (.*);

// File: verif/raycast_wall_slice_setup_test.sv
`timescale 1ns / 1ps

module raycast_wall_slice_setup_test;
  import rwss_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;

  typedef struct packed {
    logic [DIST_W-1:0]       hit_dist;
    logic                    side;
    logic                    sxp;
    logic                    syp;
    logic [POS_W-1:0]        px;
    logic [POS_W-1:0]        py;
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;
  } column_t;

  typedef struct packed {
    face_t               face;
    logic [HEIGHT_W-1:0] height;
    logic [ROW_W-1:0]    top;
    logic [ROW_W-1:0]    bottom;
    logic [COL_W-1:0]    texcol;
  } slice_t;

  typedef struct packed {
    column_t col;
    logic    known;
    slice_t  want;
  } row_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [1:0]              cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [DIST_W-1:0]       distance;
  logic                    horizontal_hit;
  logic                    step_x_positive;
  logic                    step_y_positive;
  logic [POS_W-1:0]        player_x;
  logic [POS_W-1:0]        player_y;
  logic signed [DIR_W-1:0] ray_dx;
  logic signed [DIR_W-1:0] ray_dy;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              face;
  logic [HEIGHT_W-1:0]     slice_height;
  logic [ROW_W-1:0]        start_row;
  logic [ROW_W-1:0]        end_row;
  logic [COL_W-1:0]        texture_column;

  logic [BS_W-1:0] cur_block_size     = BLOCK_SIZE_RST;
  logic [PD_W-1:0] cur_plane_distance = PLANE_DISTANCE_RST;
  logic [TW_W-1:0] cur_tex_width      = TEX_WIDTH_RST;

  slice_t pending_slices[$];
  row_t   directed_rows[$];
  slice_t no_slice;
  bit     no_idle = 1'b0;
  int     mismatches = 0;
  int     slices_seen = 0;
  int     cycles = 0;

  raycast_wall_slice_setup uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .distance        (distance),
    .horizontal_hit  (horizontal_hit),
    .step_x_positive (step_x_positive),
    .step_y_positive (step_y_positive),
    .player_x        (player_x),
    .player_y        (player_y),
    .ray_dx          (ray_dx),
    .ray_dy          (ray_dy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .face            (face),
    .slice_height    (slice_height),
    .start_row       (start_row),
    .end_row         (end_row),
    .texture_column  (texture_column)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Projects one wall column with the settings currently loaded.
  function automatic slice_t project_column(column_t c);
    slice_t      s;
    logic [63:0] span;
    logic [63:0] quot;
    logic [63:0] coord;
    logic [63:0] scaled;
    logic [31:0] pos;
    longint      d;
    longint      dir;
    int          half;
    int          top;
    int          bottom;
    if (!c.side) begin
      s.face = c.sxp ? FACE_EAST : FACE_WEST;
    end else begin
      s.face = c.syp ? FACE_SOUTH : FACE_NORTH;
    end
    if (c.hit_dist == '0) begin
      s.height = 16'hFFFF;
    end else begin
      span = (64'(cur_block_size) * 64'(cur_plane_distance)) << FRAC_BITS;
      quot = span / 64'(c.hit_dist);
      s.height = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
    end
    half = int'(s.height) / 2;
    top = (half >= SCREEN_ROWS / 2) ? 0 : SCREEN_ROWS / 2 - half;
    bottom = top + int'(s.height);
    if (bottom > SCREEN_ROWS) bottom = SCREEN_ROWS;
    s.top = ROW_W'(top);
    s.bottom = ROW_W'(bottom);
    // The hit coordinate carries 32 fraction bits; a negative product wraps
    // so that the fraction still lies in [0, 1).
    pos = c.side ? c.px : c.py;
    dir = c.side ? longint'($signed(c.dx)) : longint'($signed(c.dy));
    d = {32'b0, c.hit_dist};
    coord = ({32'b0, pos} << FRAC_BITS) + 64'(d * dir);
    scaled = {32'b0, coord[31:0]} * 64'(cur_tex_width);
    s.texcol = scaled[2*FRAC_BITS +: COL_W];
    return s;
  endfunction

  function automatic column_t make_col(logic [31:0] hd, logic side, logic sxp, logic syp,
                                       logic [31:0] px, logic [31:0] py,
                                       logic [19:0] dx, logic [19:0] dy);
    column_t c;
    c.hit_dist = hd;
    c.side = side;
    c.sxp = sxp;
    c.syp = syp;
    c.px = px;
    c.py = py;
    c.dx = dx;
    c.dy = dy;
    return c;
  endfunction

  function automatic slice_t make_slice(face_t f, int h, int top, int bottom, int tc);
    slice_t s;
    s.face = f;
    s.height = HEIGHT_W'(h);
    s.top = ROW_W'(top);
    s.bottom = ROW_W'(bottom);
    s.texcol = COL_W'(tc);
    return s;
  endfunction

  function automatic logic [DIR_W-1:0] random_dir();
    case ($urandom_range(7))
      0: return {1'b1, {(DIR_W-1){1'b0}}};
      1: return {1'b0, {(DIR_W-1){1'b1}}};
      2: return DIR_W'($urandom_range(0, 32'h1FFFF)) - DIR_W'(32'h10000);
      default: return DIR_W'($urandom);
    endcase
  endfunction

  function automatic column_t random_column();
    column_t c;
    case ($urandom_range(9))
      0: c.hit_dist = '0;
      1: c.hit_dist = $urandom_range(1, 255);
      2, 3: c.hit_dist = $urandom;
      default: c.hit_dist = $urandom_range(32'h4000, 32'h80_0000);
    endcase
    c.side = 1'($urandom_range(1));
    c.sxp = 1'($urandom_range(1));
    c.syp = 1'($urandom_range(1));
    c.px = $urandom_range(1) ? $urandom : $urandom_range(0, 32'h40_0000);
    c.py = $urandom_range(1) ? $urandom : $urandom_range(0, 32'h40_0000);
    c.dx = random_dir();
    c.dy = random_dir();
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at slice %0d: %s", slices_seen, msg);
    mismatches++;
  endtask

  // Holds the item until the block takes it, then files its expected slice.
  task automatic send_column(column_t c, logic known, slice_t want);
    int gap;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(99) < 12) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    distance        <= c.hit_dist;
    horizontal_hit  <= c.side;
    step_x_positive <= c.sxp;
    step_y_positive <= c.syp;
    player_x        <= c.px;
    player_y        <= c.py;
    ray_dx          <= c.dx;
    ray_dy          <= c.dy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_slices.push_back(known ? want : project_column(c));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_slices.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Settings change only once the pipeline has emptied.
  task automatic load_settings(logic [BS_W-1:0] bs, logic [PD_W-1:0] pd,
                               logic [TW_W-1:0] tw);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BLOCK_SIZE;
    cfg_data  <= CFG_W'(bs);
    @(posedge clk);
    cur_block_size = bs;
    cfg_index <= CFG_PLANE_DISTANCE;
    cfg_data  <= CFG_W'(pd);
    @(posedge clk);
    cur_plane_distance = pd;
    cfg_index <= CFG_TEX_WIDTH;
    cfg_data  <= CFG_W'(tw);
    @(posedge clk);
    cur_tex_width = tw;
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [BS_W-1:0] bs, logic [PD_W-1:0] pd,
                           logic [TW_W-1:0] tw, int count, bit calm);
    load_settings(bs, pd, tw);
    no_idle = calm;
    repeat (count) send_column(random_column(), 1'b0, no_slice);
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    slice_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_slices.size() == 0) begin
        report_mismatch("wall slice arrived with nothing expected");
      end else begin
        want = pending_slices.pop_front();
        if (face !== want.face)
          report_mismatch($sformatf("face got %0d, expected %0d", face, want.face));
        if (slice_height !== want.height)
          report_mismatch($sformatf("slice_height got %0d, expected %0d",
                                    slice_height, want.height));
        if (start_row !== want.top)
          report_mismatch($sformatf("start_row got %0d, expected %0d", start_row, want.top));
        if (end_row !== want.bottom)
          report_mismatch($sformatf("end_row got %0d, expected %0d", end_row, want.bottom));
        if (texture_column !== want.texcol)
          report_mismatch($sformatf("texture_column got %0d, expected %0d",
                                    texture_column, want.texcol));
      end
      slices_seen++;
    end
    out_stall <= !no_idle && ($urandom_range(99) < 12);
  end

  initial begin
    int i;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_BLOCK_SIZE;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    distance        <= '0;
    horizontal_hit  <= 1'b0;
    step_x_positive <= 1'b0;
    step_y_positive <= 1'b0;
    player_x        <= '0;
    player_y        <= '0;
    ray_dx          <= '0;
    ray_dy          <= '0;
    out_stall       <= 1'b0;

    // Rows checked by hand assume the reset settings: block 64, plane 512,
    // texture 64, so the height numerator is 2^31.
    directed_rows.push_back('{make_col(32'h0, 0, 1, 0, 0, 0, 0, 0), 1'b1,
                              make_slice(FACE_EAST, 65535, 0, 1024, 0)});
    directed_rows.push_back('{make_col(32'h1_0000, 0, 0, 1, 0, 0, 0, 0), 1'b1,
                              make_slice(FACE_WEST, 32768, 0, 1024, 0)});
    directed_rows.push_back('{make_col(32'hFFFF_FFFF, 1, 0, 1, 0, 0, 0, 0), 1'b1,
                              make_slice(FACE_SOUTH, 0, 512, 512, 0)});
    directed_rows.push_back('{make_col(32'h40_0000, 1, 1, 0, 32'h8000, 0, 0, 0), 1'b1,
                              make_slice(FACE_NORTH, 512, 256, 768, 32)});
    directed_rows.push_back('{make_col(32'h1, 0, 1, 1, 0, 0, 0, 0), 1'b1,
                              make_slice(FACE_EAST, 65535, 0, 1024, 0)});
    directed_rows.push_back('{make_col(32'h80_0000, 0, 1, 0, 0, 32'hC000, 0, 0), 1'b1,
                              make_slice(FACE_EAST, 256, 384, 640, 48)});
    directed_rows.push_back('{make_col(32'h20_0000, 1, 0, 1, 0, 0, 0, 0), 1'b1,
                              make_slice(FACE_SOUTH, 1024, 0, 1024, 0)});
    directed_rows.push_back('{make_col(32'h20_0001, 1, 1, 0, 0, 0, 0, 0), 1'b1,
                              make_slice(FACE_NORTH, 1023, 1, 1024, 0)});
    directed_rows.push_back('{make_col(32'h8000_0000, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              make_slice(FACE_WEST, 1, 512, 513, 0)});
    directed_rows.push_back('{make_col(32'h1_0000, 0, 1, 0, 0, 32'hFFFF, 0, 0), 1'b1,
                              make_slice(FACE_EAST, 32768, 0, 1024, 63)});
    // A negative direction must still give a column in range.
    directed_rows.push_back('{make_col(32'h1_0000, 0, 0, 0, 0, 0, 0, 20'hFFFFF), 1'b0,
                              no_slice});
    directed_rows.push_back('{make_col(32'hFFFF_FFFF, 0, 1, 1, 0, 32'hFFFF_FFFF, 0,
                                       20'h80000), 1'b0, no_slice});
    directed_rows.push_back('{make_col(32'hFFFF_FFFF, 0, 0, 1, 0, 0, 0, 20'h7FFFF), 1'b0,
                              no_slice});
    directed_rows.push_back('{make_col(32'h1234_5678, 1, 1, 1, 32'hFFFF_FFFF, 0,
                                       20'h80000, 0), 1'b0, no_slice});
    directed_rows.push_back('{make_col(32'h0003_8000, 1, 0, 0, 32'hDEAD_BEEF, 0,
                                       20'h7FFFF, 0), 1'b0, no_slice});
    directed_rows.push_back('{make_col(32'h1_0000, 0, 1, 1, 0, 32'h1_0000, 0, 20'h08000),
                              1'b0, no_slice});

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < directed_rows.size(); i++)
      send_column(directed_rows[i].col, directed_rows[i].known, directed_rows[i].want);

    run_phase(13'd64, 16'd512, 13'd64, 40, 1'b0);
    // Zero block size and zero texture width.
    run_phase(13'd0, 16'd512, 13'd0, 30, 1'b0);
    run_phase(13'd64, 16'd0, 13'd64, 30, 1'b0);
    // Texture widths above 4096 wrap the column to its low 12 bits.
    run_phase(13'h1FFF, 16'hFFFF, 13'h1FFF, 50, 1'b0);
    run_phase(13'd1, 16'd1, 13'd1, 30, 1'b0);
    run_phase(13'd4096, 16'hFFFF, 13'd4096, 60, 1'b1);
    run_phase(13'd1, 16'hFFFF, 13'd4097, 40, 1'b0);
    for (i = 0; i < 5; i++)
      run_phase(BS_W'($urandom_range(1, 4096)), PD_W'($urandom_range(1, 65535)),
                TW_W'($urandom_range(1, 4096)), 44, 1'b0);

    wait_drained();
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rwss_pkg.sv
rtl/rwss_div_step.sv
rtl/raycast_wall_slice_setup.sv
rtl/rwss_checker.sv
verif/raycast_wall_slice_setup_test.sv
